### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// Three-wire serial master package
// Action codes, register default and stream field positions.
// ----------------------------------------------------------------------------
`default_nettype none

package twrtc_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [7:0] TICKS_PER_PHASE_RESET = 8'd4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Request data positions.
   localparam int REQ_CMD_LSB  = 0;
   localparam int REQ_WR_LSB   = 8;
   localparam int REQ_PIN_BIT  = 16;

   // Response data positions.
   localparam int RSP_CE_BIT   = 0;
   localparam int RSP_CLK_BIT  = 1;
   localparam int RSP_DOUT_BIT = 2;
   localparam int RSP_DEN_BIT  = 3;
   localparam int RSP_BUSY_BIT = 4;
   localparam int RSP_DONE_BIT = 5;
   localparam int RSP_RD_LSB   = 6;

endpackage

`default_nettype wire

### hw/rtl/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// Three-wire serial master
// Chip enable, serial clock and bidirectional data, LSB first.
// ----------------------------------------------------------------------------
// Each request is a tick, a start or action code 3. A start opens a write
// or read transaction on the wire; ticks pace the wire, ticks_per_phase ticks
// per setup, clock-low and clock-high phase. Every request yields exactly one
// response carrying the pin levels and status after that request. The block
// takes one request per clock cycle; its response is available in the next
// cycle from a single output register, and a request is taken whenever that
// register is empty or is being drained in the same cycle. Starts while busy
// and action code 3 change nothing. Write ticks_per_phase only while idle.
`default_nettype none

module three_wire_rtc_serial_master (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] command_byte, [15:8] write_byte, [16] data_pin_in, [23:17] zero
   input  wire logic [twrtc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] action
   input  wire logic [1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] chip_enable, [1] serial_clock, [2] data_pin_out,
   // [3] data_drive_enable, [4] busy_res, [5] done_res, [13:6] read_byte,
   // [15:14] zero
   output logic [twrtc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [7:0]                         csr_data
);
   import twrtc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SETUP     = 3'd1,
      PH_TX_LOW    = 3'd2,
      PH_TX_HIGH   = 3'd3,
      PH_RX_LOW    = 3'd4,
      PH_RX_HIGH   = 3'd5,
      PH_RX_SAMPLE = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_idx_ff, bit_idx_in;
   logic [7:0] shift_out_ff, shift_out_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] shift_in_ff, shift_in_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] tpp_ff, tpp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic       accept;
   action_type action;
   logic [7:0] cmd_byte;
   logic [7:0] wr_byte;
   logic       pin;
   logic [7:0] limit;
   logic [7:0] ticks_inc;
   logic [3:0] bit_inc;
   logic       done;
   logic       ce, clk, dout, den;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign action   = action_type'(req_tuser);
   assign cmd_byte = req_tdata[REQ_CMD_LSB +: 8];
   assign wr_byte  = req_tdata[REQ_WR_LSB +: 8];
   assign pin      = req_tdata[REQ_PIN_BIT];

   assign limit     = (tpp_ff == 8'd0) ? 8'd1 : tpp_ff;
   assign ticks_inc = ticks_ff + 8'd1;
   assign bit_inc   = bit_idx_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_idx_in   = bit_idx_ff;
      shift_out_in = shift_out_ff;
      pending_in   = pending_ff;
      shift_in_in  = shift_in_ff;
      ticks_in     = ticks_ff;
      is_read_in   = is_read_ff;
      done         = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (action == ACT_WRITE || action == ACT_READ) begin
            shift_out_in = cmd_byte;
            pending_in   = wr_byte;
            is_read_in   = (action == ACT_READ);
            bit_idx_in   = 4'd0;
            ticks_in     = 8'd0;
            phase_in     = PH_SETUP;
         end
      end else if (action == ACT_TICK) begin
         ticks_in = ticks_inc;
         if (ticks_inc >= limit) begin
            ticks_in = 8'd0;
            case (phase_ff)
               PH_SETUP: begin
                  phase_in = PH_TX_LOW;
               end
               PH_TX_LOW: begin
                  phase_in = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  shift_out_in = {1'b0, shift_out_ff[7:1]};
                  bit_idx_in   = bit_inc;
                  if (bit_inc == 4'd8 && is_read_ff) begin
                     bit_idx_in   = 4'd0;
                     shift_out_in = 8'd0;
                     phase_in     = PH_RX_LOW;
                  end else if (bit_inc == 4'd8) begin
                     shift_out_in = pending_ff;
                     phase_in     = PH_TX_LOW;
                  end else if (bit_inc == 4'd0) begin
                     // Sixteen bits sent: the write transaction is complete.
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_TX_LOW;
                  end
               end
               PH_RX_LOW: begin
                  phase_in = PH_RX_HIGH;
               end
               PH_RX_HIGH: begin
                  phase_in = PH_RX_SAMPLE;
               end
               PH_RX_SAMPLE: begin
                  shift_out_in = {pin, shift_out_ff[7:1]};
                  bit_idx_in   = bit_inc;
                  if (bit_inc >= 4'd8) begin
                     shift_in_in = {pin, shift_out_ff[7:1]};
                     bit_idx_in  = 4'd0;
                     phase_in    = PH_IDLE;
                     done        = 1'b1;
                  end else begin
                     phase_in = PH_RX_LOW;
                  end
               end
               default: begin
                  bit_idx_in = 4'd0;
                  phase_in   = PH_IDLE;
               end
            endcase
         end
      end

      ce   = 1'b0;
      clk  = 1'b0;
      dout = 1'b0;
      den  = 1'b1;
      case (phase_in)
         PH_SETUP: begin
            ce = 1'b1;
         end
         PH_TX_LOW: begin
            ce   = 1'b1;
            dout = shift_out_in[0];
         end
         PH_TX_HIGH: begin
            ce   = 1'b1;
            clk  = 1'b1;
            dout = shift_out_in[0];
         end
         PH_RX_LOW, PH_RX_SAMPLE: begin
            ce  = 1'b1;
            den = 1'b0;
         end
         PH_RX_HIGH: begin
            ce  = 1'b1;
            clk = 1'b1;
            den = 1'b0;
         end
         default: begin
            ce = 1'b0;
         end
      endcase

      rsp_data_in = '0;
      rsp_data_in[RSP_CE_BIT]       = ce;
      rsp_data_in[RSP_CLK_BIT]      = clk;
      rsp_data_in[RSP_DOUT_BIT]     = dout;
      rsp_data_in[RSP_DEN_BIT]      = den;
      rsp_data_in[RSP_BUSY_BIT]     = (phase_in != PH_IDLE);
      rsp_data_in[RSP_DONE_BIT]     = done;
      rsp_data_in[RSP_RD_LSB +: 8]  = shift_in_in;

      tpp_in = csr_valid ? csr_data : tpp_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_idx_ff   <= 4'd0;
         shift_out_ff <= 8'd0;
         pending_ff   <= 8'd0;
         shift_in_ff  <= 8'd0;
         ticks_ff     <= 8'd0;
         is_read_ff   <= 1'b0;
         tpp_ff       <= TICKS_PER_PHASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            bit_idx_ff   <= bit_idx_in;
            shift_out_ff <= shift_out_in;
            pending_ff   <= pending_in;
            shift_in_ff  <= shift_in_in;
            ticks_ff     <= ticks_in;
            is_read_ff   <= is_read_in;
         end
         tpp_ff       <= tpp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/twrtc_checker.sv
// ----------------------------------------------------------------------------
// Three-wire serial master checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module twrtc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [twrtc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import twrtc_pkg::*;

   logic ce, clk, den, busy, done;

   assign ce   = rsp_tdata[RSP_CE_BIT];
   assign clk  = rsp_tdata[RSP_CLK_BIT];
   assign den  = rsp_tdata[RSP_DEN_BIT];
   assign busy = rsp_tdata[RSP_BUSY_BIT];
   assign done = rsp_tdata[RSP_DONE_BIT];

   // A stalled response holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Every accepted request produces a response in the next cycle.
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // The serial clock and a released data line only occur inside a transaction.
   `ASSERT_IMPLIES(a_clk_in_txn, clock, reset, rsp_tvalid && (clk || !den), ce && busy)

   // A completing transaction leaves the wire idle.
   `ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_tvalid && done, !busy && !ce && den)

endmodule

bind three_wire_rtc_serial_master twrtc_checker u_twrtc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### dv/tb_three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// Three-wire serial master testbench
// Drives ticks, starts and ACT_NONE into the request stream and predicts the
// pin levels and status for each one. Every response is checked field by
// field in order. Runs a short directed table under the reset divider, then
// random phases under several divider settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_three_wire_rtc_serial_master;
   import twrtc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int NUM_PHASES  = 8;

   // Wire sequencer phases, as the block steps through them.
   typedef enum logic [2:0] {
      SQ_IDLE      = 3'd0,
      SQ_SETUP     = 3'd1,
      SQ_TX_LOW    = 3'd2,
      SQ_TX_HIGH   = 3'd3,
      SQ_RX_LOW    = 3'd4,
      SQ_RX_HIGH   = 3'd5,
      SQ_RX_SAMPLE = 3'd6
   } seq_phase_type;

   typedef struct {
      logic       ce;
      logic       sclk;
      logic       dout;
      logic       den;
      logic       busy;
      logic       done;
      logic [7:0] rbyte;
      logic [1:0] pad;
   } wire_levels_type;

   typedef struct {
      action_type act;
      logic [7:0] cmd;
      logic [7:0] wr;
      logic       pin;
      int         reps;
      logic       typed;
      logic [15:0] want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = ACT_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data = '0;

   three_wire_rtc_serial_master u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Predicted sequencer state and divider.
   seq_phase_type sq_phase;
   logic [3:0] sq_bits;
   logic [7:0] sq_shift;
   logic [7:0] sq_wbyte;
   logic [7:0] sq_rbyte;
   logic [7:0] sq_ticks;
   logic       sq_is_read;
   logic [7:0] sq_div;

   wire_levels_type pending_levels[$];
   wire_levels_type got_lv;
   wire_levels_type want_lv;
   stim_row_type    dir_rows[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_gap_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_left = 0;

   int phase_div   [NUM_PHASES] = '{1, 2, 0, 3, 1, 2, 0, 1};
   int phase_items [NUM_PHASES] = '{30, 30, 30, 30, 30, 30, 30, 30};

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_three_wire_rtc_serial_master: errors");
         $finish;
      end
   end

   function automatic wire_levels_type unpack_levels(input logic [RSP_DATA_W-1:0] w);
      wire_levels_type lv;
      lv.ce    = w[RSP_CE_BIT];
      lv.sclk  = w[RSP_CLK_BIT];
      lv.dout  = w[RSP_DOUT_BIT];
      lv.den   = w[RSP_DEN_BIT];
      lv.busy  = w[RSP_BUSY_BIT];
      lv.done  = w[RSP_DONE_BIT];
      lv.rbyte = w[RSP_RD_LSB +: 8];
      lv.pad   = w[RSP_DATA_W-1 -: 2];
      return lv;
   endfunction

   // Advances the predicted sequencer by one request and returns the levels
   // that the block should show afterwards.
   function automatic wire_levels_type next_wire_levels(input action_type act,
                                                        input logic [7:0] cmd,
                                                        input logic [7:0] wr,
                                                        input logic pin);
      wire_levels_type lv;
      logic [7:0]   lim;
      logic         done;
      done = 1'b0;
      if (sq_phase == SQ_IDLE) begin
         if (act == ACT_WRITE || act == ACT_READ) begin
            sq_shift   = cmd;
            sq_wbyte   = wr;
            sq_is_read = (act == ACT_READ);
            sq_bits    = '0;
            sq_ticks   = '0;
            sq_phase   = SQ_SETUP;
         end
      end else if (act == ACT_TICK) begin
         lim = (sq_div == 8'd0) ? 8'd1 : sq_div;
         sq_ticks = sq_ticks + 8'd1;
         if (sq_ticks >= lim) begin
            sq_ticks = '0;
            case (sq_phase)
               SQ_SETUP:   sq_phase = SQ_TX_LOW;
               SQ_TX_LOW:  sq_phase = SQ_TX_HIGH;
               SQ_TX_HIGH: begin
                  sq_shift = sq_shift >> 1;
                  sq_bits  = sq_bits + 4'd1;
                  if (sq_bits == 4'd8 && sq_is_read) begin
                     // Command sent; release the line and gather from zero.
                     sq_bits  = '0;
                     sq_shift = '0;
                     sq_phase = SQ_RX_LOW;
                  end else if (sq_bits == 4'd8) begin
                     sq_shift = sq_wbyte;
                     sq_phase = SQ_TX_LOW;
                  end else if (sq_bits == 4'd0) begin
                     sq_phase = SQ_IDLE;
                     done     = 1'b1;
                  end else begin
                     sq_phase = SQ_TX_LOW;
                  end
               end
               SQ_RX_LOW:  sq_phase = SQ_RX_HIGH;
               SQ_RX_HIGH: sq_phase = SQ_RX_SAMPLE;
               SQ_RX_SAMPLE: begin
                  sq_shift = {pin, sq_shift[7:1]};
                  sq_bits  = sq_bits + 4'd1;
                  if (sq_bits >= 4'd8) begin
                     sq_rbyte = sq_shift;
                     sq_bits  = '0;
                     sq_phase = SQ_IDLE;
                     done     = 1'b1;
                  end else begin
                     sq_phase = SQ_RX_LOW;
                  end
               end
               default: sq_phase = SQ_IDLE;
            endcase
         end
      end
      lv.ce    = (sq_phase != SQ_IDLE);
      lv.sclk  = (sq_phase == SQ_TX_HIGH || sq_phase == SQ_RX_HIGH);
      lv.dout  = (sq_phase == SQ_TX_LOW || sq_phase == SQ_TX_HIGH) && sq_shift[0];
      lv.den   = !(sq_phase == SQ_RX_LOW || sq_phase == SQ_RX_HIGH ||
                   sq_phase == SQ_RX_SAMPLE);
      lv.busy  = (sq_phase != SQ_IDLE);
      lv.done  = done;
      lv.rbyte = sq_rbyte;
      lv.pad   = '0;
      return lv;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: the ready pattern follows the current stall setting, with
   // a long hold-off whenever hold_left is loaded.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_lv = unpack_levels(rsp_tdata);
         if (pending_levels.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual %0h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want_lv = pending_levels.pop_front();
            check_field("chip_enable", 8'(want_lv.ce), 8'(got_lv.ce));
            check_field("serial_clock", 8'(want_lv.sclk), 8'(got_lv.sclk));
            check_field("data_pin_out", 8'(want_lv.dout), 8'(got_lv.dout));
            check_field("data_drive_enable", 8'(want_lv.den), 8'(got_lv.den));
            check_field("busy", 8'(want_lv.busy), 8'(got_lv.busy));
            check_field("done", 8'(want_lv.done), 8'(got_lv.done));
            check_field("read_byte", want_lv.rbyte, got_lv.rbyte);
            check_field("padding", 8'(want_lv.pad), 8'(got_lv.pad));
         end
      end
   end

   // Offers one request transaction and records its expected response. Called
   // and left just after a falling edge.
   task automatic send_req(input action_type act, input logic [7:0] cmd,
                           input logic [7:0] wr, input logic pin,
                           input logic typed, input logic [15:0] want);
      logic [REQ_DATA_W-1:0] word;
      wire_levels_type       lv;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      word = '0;
      word[REQ_CMD_LSB +: 8] = cmd;
      word[REQ_WR_LSB +: 8]  = wr;
      word[REQ_PIN_BIT]      = pin;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      lv = next_wire_levels(act, cmd, wr, pin);
      if (typed) lv = unpack_levels(want);
      pending_levels.push_back(lv);
      @(negedge clock);
   endtask

   task automatic random_req(output logic counts);
      action_type act;
      int         r;
      r = $urandom_range(99);
      if (sq_phase == SQ_IDLE) begin
         if (r < 80)      act = ($urandom_range(1) != 0) ? ACT_READ : ACT_WRITE;
         else if (r < 92) act = ACT_TICK;
         else             act = ACT_NONE;
         counts = (act == ACT_READ || act == ACT_WRITE);
      end else begin
         if (r < 90)      act = ACT_TICK;
         else if (r < 95) act = ($urandom_range(1) != 0) ? ACT_READ : ACT_WRITE;
         else             act = ACT_NONE;
         counts = (act == ACT_TICK);
      end
      send_req(act, 8'($urandom_range(255)), 8'($urandom_range(255)),
               1'($urandom_range(1)), 1'b0, '0);
   endtask

   initial begin
      logic counts;
      int   done_items;
      sq_phase   = SQ_IDLE;
      sq_bits    = '0;
      sq_shift   = '0;
      sq_wbyte   = '0;
      sq_rbyte   = '0;
      sq_ticks   = '0;
      sq_is_read = 1'b0;
      sq_div     = TICKS_PER_PHASE_RESET;

      // Directed table under the reset divider of 4: a write transaction is
      // 132 ticks and a read transaction 164 ticks.
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0008});
      dir_rows.push_back('{ACT_NONE,  8'hFF, 8'hFF, 1'b1, 1,   1'b1, 16'h0008});
      dir_rows.push_back('{ACT_WRITE, 8'hFF, 8'h00, 1'b0, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_READ,  8'h00, 8'hFF, 1'b1, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_NONE,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b0, 132, 1'b0, 16'h0000});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0008});
      dir_rows.push_back('{ACT_READ,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b1, 164, 1'b0, 16'h0000});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h3FC8});
      dir_rows.push_back('{ACT_WRITE, 8'h55, 8'hAA, 1'b1, 1,   1'b1, 16'h3FD9});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b1, 132, 1'b0, 16'h0000});
      dir_rows.push_back('{ACT_READ,  8'hAA, 8'h55, 1'b1, 1,   1'b1, 16'h3FD9});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b0, 164, 1'b0, 16'h0000});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b1, 1,   1'b1, 16'h0008});
      dir_rows.push_back('{ACT_READ,  8'h80, 8'h01, 1'b0, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b1, 3,   1'b0, 16'h0000});
      dir_rows.push_back('{ACT_WRITE, 8'h01, 8'h80, 1'b1, 1,   1'b1, 16'h0019});
      dir_rows.push_back('{ACT_TICK,  8'h00, 8'h00, 1'b1, 161, 1'b0, 16'h0000});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++) begin
            send_req(dir_rows[i].act, dir_rows[i].cmd, dir_rows[i].wr, dir_rows[i].pin,
                     dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Let the wire finish and every response drain before the divider
         // moves; the register is only safe to touch while idle.
         while (sq_phase != SQ_IDLE) begin
            send_req(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'b0, '0);
         end
         req_tvalid <= 1'b0;
         while (pending_levels.size() != 0) @(posedge clock);
         repeat (4) @(negedge clock);

         csr_valid <= 1'b1;
         csr_data  <= 8'(phase_div[p]);
         do @(posedge clock); while (!csr_ready);
         sq_div = 8'(phase_div[p]);
         @(negedge clock);
         csr_valid <= 1'b0;

         case (p % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_gap_pct = 31; rsp_stall_pct = 31; end
         endcase
         // Hold the response side off while requests keep coming, so the
         // block fills up and pushes back on the request stream.
         if (p == 0) hold_left = 300;

         done_items = 0;
         while (done_items < phase_items[p]) begin
            random_req(counts);
            if (counts) done_items++;
         end
      end

      while (sq_phase != SQ_IDLE) begin
         send_req(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_three_wire_rtc_serial_master: clean");
      end else begin
         $display("tb_three_wire_rtc_serial_master: errors");
      end
      $finish;
   end

endmodule
